// File: hw/rtl/triangle_tangent_basis_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triangle tangent basis unit
// Shared property forms with clock and reset passed in.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_TANGENT_BASIS_UNIT_ASSERT_SVH
`define TRIANGLE_TANGENT_BASIS_UNIT_ASSERT_SVH

// condition must never hold outside reset
`define TTB_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

// same-cycle implication
`define TTB_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TTB_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ttb_pkg.sv
// ----------------------------------------------------------------------------
// ttb_pkg
// Types and constants for the triangle tangent basis unit.
// ----------------------------------------------------------------------------
package ttb_pkg;

  localparam int unsigned TTB_IDX_W   = 10;
  localparam int unsigned TTB_COORD_W = 16;
  localparam int unsigned TTB_DELTA_W = 17;
  localparam int unsigned TTB_PROD_W  = 34;
  localparam int unsigned TTB_ACC_W   = 36;
  localparam int unsigned TTB_MAG_W   = 35;
  localparam int unsigned TTB_DEN_W   = 34;
  localparam int unsigned TTB_QUO_W   = 33;
  localparam int unsigned TTB_SAT_SH  = 12;
  localparam int unsigned TTB_RES_W   = 32;

  typedef enum logic [1:0] {
    KIND_WRITE    = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_READ     = 2'd2
  } ttb_kind_e;

  typedef struct packed {
    logic [1:0]                     kind;
    logic [TTB_IDX_W-1:0]           vertex_index;
    logic signed [TTB_COORD_W-1:0]  pos_x;
    logic signed [TTB_COORD_W-1:0]  pos_y;
    logic signed [TTB_COORD_W-1:0]  pos_z;
    logic signed [TTB_COORD_W-1:0]  tex_u;
    logic signed [TTB_COORD_W-1:0]  tex_v;
    logic [TTB_IDX_W-1:0]           corner_a;
    logic [TTB_IDX_W-1:0]           corner_b;
    logic [TTB_IDX_W-1:0]           corner_c;
  } ttb_in_t;

  typedef struct packed {
    logic                         degenerate;
    logic signed [TTB_RES_W-1:0]  tan_x;
    logic signed [TTB_RES_W-1:0]  tan_y;
    logic signed [TTB_RES_W-1:0]  tan_z;
    logic signed [TTB_RES_W-1:0]  bitan_x;
    logic signed [TTB_RES_W-1:0]  bitan_y;
    logic signed [TTB_RES_W-1:0]  bitan_z;
  } ttb_out_t;

  typedef struct packed {
    logic signed [TTB_COORD_W-1:0] pos_x;
    logic signed [TTB_COORD_W-1:0] pos_y;
    logic signed [TTB_COORD_W-1:0] pos_z;
    logic signed [TTB_COORD_W-1:0] tex_u;
    logic signed [TTB_COORD_W-1:0] tex_v;
  } ttb_vertex_t;

  typedef struct packed {
    logic signed [TTB_RES_W-1:0] tan_x;
    logic signed [TTB_RES_W-1:0] tan_y;
    logic signed [TTB_RES_W-1:0] tan_z;
    logic signed [TTB_RES_W-1:0] bitan_x;
    logic signed [TTB_RES_W-1:0] bitan_y;
    logic signed [TTB_RES_W-1:0] bitan_z;
  } ttb_basis_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ttb_div_status_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_FIN,
    DIV_DONE
  } ttb_div_state_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ_WAIT,
    ST_FETCH_A,
    ST_FETCH_B,
    ST_FETCH_C,
    ST_FETCH_END,
    ST_DELTA,
    ST_DET0,
    ST_DET1,
    ST_DET_CHK,
    ST_NUM0,
    ST_NUM1,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_WB
  } ttb_state_e;

endpackage

// File: hw/rtl/ttb_divider.sv
// ----------------------------------------------------------------------------
// ttb_divider
// Bit-serial restoring divider: round(num * 2^20 / den), ties away from
// zero, saturated to 32 bits signed. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module ttb_divider (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic signed [ttb_pkg::TTB_ACC_W-1:0]     num_i,
  input  logic signed [ttb_pkg::TTB_ACC_W-1:0]     den_i,
  output ttb_pkg::ttb_div_status_t                 status_o,
  output logic signed [ttb_pkg::TTB_RES_W-1:0]     result_o
);
  import ttb_pkg::*;

  ttb_div_state_e state_q, state_d;

  logic                    neg_q;
  logic                    sat_q;
  logic [TTB_DEN_W-1:0]    rem_q;
  logic [TTB_DEN_W-1:0]    den_q;
  logic [TTB_QUO_W-1:0]    quo_q;
  logic [5:0]              cnt_q;
  logic signed [TTB_RES_W-1:0] result_q;

  logic [TTB_ACC_W-1:0]    num_abs;
  logic [TTB_ACC_W-1:0]    den_abs;
  logic [TTB_MAG_W-1:0]    num_mag;
  logic [TTB_DEN_W-1:0]    den_mag;
  logic [TTB_DEN_W-1:0]    num_hi;
  logic [TTB_DEN_W:0]      rem_sh;
  logic                    ge;
  logic [TTB_DEN_W:0]      rem_sub;
  logic [TTB_DEN_W:0]      rnd_sum;
  logic [TTB_QUO_W-1:0]    rnd_q;
  logic signed [TTB_RES_W-1:0] fin_val;

  assign num_abs = num_i[TTB_ACC_W-1] ? TTB_ACC_W'(-num_i) : TTB_ACC_W'(num_i);
  assign den_abs = den_i[TTB_ACC_W-1] ? TTB_ACC_W'(-den_i) : TTB_ACC_W'(den_i);
  assign num_mag = num_abs[TTB_MAG_W-1:0];
  assign den_mag = den_abs[TTB_DEN_W-1:0];
  assign num_hi  = TTB_DEN_W'(num_mag[TTB_MAG_W-1:TTB_SAT_SH]);

  assign rem_sh  = {rem_q, quo_q[TTB_QUO_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  assign rnd_sum = (TTB_DEN_W+1)'(quo_q) + (TTB_DEN_W+1)'(1);
  assign rnd_q   = rnd_sum[TTB_QUO_W:1];

  always_comb begin
    if (!neg_q) begin
      if (sat_q || (rnd_q > TTB_QUO_W'(32'h7FFF_FFFF))) begin
        fin_val = 32'sh7FFF_FFFF;
      end else begin
        fin_val = signed'(rnd_q[TTB_RES_W-1:0]);
      end
    end else begin
      if (sat_q || (rnd_q >= TTB_QUO_W'(32'h8000_0000))) begin
        fin_val = 32'sh8000_0000;
      end else begin
        fin_val = -signed'(rnd_q[TTB_RES_W-1:0]);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DIV_IDLE: if (start_i) state_d = DIV_RUN;
      DIV_RUN:  if (cnt_q == 6'(TTB_QUO_W-1)) state_d = DIV_FIN;
      DIV_FIN:  state_d = DIV_DONE;
      DIV_DONE: state_d = DIV_IDLE;
      default:  state_d = DIV_IDLE;
    endcase
  end

  always_comb begin
    status_o.busy = (state_q != DIV_IDLE);
    status_o.done = (state_q == DIV_DONE);
  end

  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == DIV_IDLE) begin
        cnt_q <= '0;
      end else if (state_q == DIV_RUN) begin
        cnt_q <= cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DIV_IDLE: begin
        if (start_i) begin
          neg_q <= num_i[TTB_ACC_W-1] ^ den_i[TTB_ACC_W-1];
          sat_q <= num_hi >= den_mag;
          rem_q <= num_hi;
          den_q <= den_mag;
          quo_q <= {num_mag[TTB_SAT_SH-1:0], (TTB_QUO_W-TTB_SAT_SH)'(0)};
        end
      end
      DIV_RUN: begin
        rem_q <= ge ? rem_sub[TTB_DEN_W-1:0] : rem_sh[TTB_DEN_W-1:0];
        quo_q <= {quo_q[TTB_QUO_W-2:0], ge};
      end
      DIV_FIN:  result_q <= fin_val;
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/triangle_tangent_basis_unit.sv
// ----------------------------------------------------------------------------
// triangle_tangent_basis_unit: per-triangle tangent and bitangent from UVs
// Triangle: six 33-step passes of the shared divider, basis written to all
// three corners; the next transaction is taken once the result is loaded
// into the output register. Degenerate triangle: zero result, no division.
// Vertex read: stored basis, zero if out of range. Vertex write: no result.
// Output stalls hold write-back. After reset, basis store cleared, ready low.
// ----------------------------------------------------------------------------
module triangle_tangent_basis_unit #(
  parameter int unsigned VERTEX_COUNT = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttb_pkg::ttb_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ttb_pkg::ttb_out_t out_data_o
);
  import ttb_pkg::*;

  localparam int unsigned AW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;

  ttb_state_e state_q, state_d;

  ttb_in_t     req_q;
  logic [AW-1:0] clr_q;
  ttb_vertex_t v0_q, v1_q, v2_q;
  logic signed [TTB_DELTA_W-1:0] dp1_q [3];
  logic signed [TTB_DELTA_W-1:0] dp2_q [3];
  logic signed [TTB_DELTA_W-1:0] du1_q, dv1_q, du2_q, dv2_q;
  logic signed [TTB_ACC_W-1:0]   acc_q, det_q;
  logic [1:0]  comp_q;
  logic        side_q;
  logic [1:0]  wb_q;
  logic signed [TTB_RES_W-1:0]   res_q [6];
  logic        degen_q;
  logic        out_valid_q;
  ttb_out_t    out_data_q;

  ttb_vertex_t vtx_mem [VERTEX_COUNT];
  ttb_basis_t  basis_mem [VERTEX_COUNT];
  ttb_vertex_t vtx_rd_q;
  ttb_basis_t  basis_rd_q;

  logic        accept;
  logic        idx_ok_in, tri_ok, out_load;
  logic [AW-1:0] vtx_raddr, basis_waddr;
  logic        basis_we;
  ttb_basis_t  basis_wdata, wb_row;
  logic signed [TTB_DELTA_W-1:0] mul_a, mul_b;
  logic signed [TTB_PROD_W-1:0]  prod;
  logic signed [TTB_ACC_W-1:0]   prod_ext;
  logic [2:0]  res_idx;
  logic [TTB_IDX_W-1:0] wb_corner;
  logic        div_start;
  ttb_div_status_t div_status;
  logic signed [TTB_RES_W-1:0] div_result;

  function automatic logic idx_ok(logic [TTB_IDX_W-1:0] idx);
    return 32'(idx) < VERTEX_COUNT;
  endfunction

  function automatic logic signed [TTB_DELTA_W-1:0] sub16(
    logic signed [TTB_COORD_W-1:0] a, logic signed [TTB_COORD_W-1:0] b);
    return {a[TTB_COORD_W-1], a} - {b[TTB_COORD_W-1], b};
  endfunction

  assign accept    = in_valid_i && in_ready_o;
  assign idx_ok_in = idx_ok(in_data_i.vertex_index);
  assign tri_ok    = idx_ok(in_data_i.corner_a) && idx_ok(in_data_i.corner_b) &&
                     idx_ok(in_data_i.corner_c);
  assign out_load  = (state_q == ST_WB) && (wb_q == 2'd3) && (!out_valid_q || out_ready_i);
  assign res_idx   = side_q ? (3'(comp_q) + 3'd3) : 3'(comp_q);
  assign wb_row    = {res_q[0], res_q[1], res_q[2], res_q[3], res_q[4], res_q[5]};

  always_comb begin
    unique case (wb_q)
      2'd0:    wb_corner = req_q.corner_a;
      2'd1:    wb_corner = req_q.corner_b;
      default: wb_corner = req_q.corner_c;
    endcase
  end

  // ST_WB: wb_q 0..2 write corners, 3 hands the transaction to the output register
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == AW'(VERTEX_COUNT - 1)) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.kind)
            KIND_TRIANGLE: if (tri_ok) state_d = ST_FETCH_A;
            KIND_READ:     state_d = idx_ok_in ? ST_READ_WAIT : ST_WB;
            default:       state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ_WAIT: state_d = ST_WB;
      ST_FETCH_A:   state_d = ST_FETCH_B;
      ST_FETCH_B:   state_d = ST_FETCH_C;
      ST_FETCH_C:   state_d = ST_FETCH_END;
      ST_FETCH_END: state_d = ST_DELTA;
      ST_DELTA:     state_d = ST_DET0;
      ST_DET0:      state_d = ST_DET1;
      ST_DET1:      state_d = ST_DET_CHK;
      ST_DET_CHK:   state_d = (acc_q == '0) ? ST_WB : ST_NUM0;
      ST_NUM0:      state_d = ST_NUM1;
      ST_NUM1:      state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_status.done) begin
          state_d = (side_q && (comp_q == 2'd2)) ? ST_WB : ST_NUM0;
        end
      end
      ST_WB:   if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o  = (state_q == ST_IDLE);
    div_start   = (state_q == ST_DIV_START);
    basis_we    = 1'b0;
    basis_waddr = AW'(in_data_i.vertex_index);
    basis_wdata = '0;
    vtx_raddr   = AW'(req_q.corner_c);
    unique case (state_q)
      ST_CLEAR: begin
        basis_we    = 1'b1;
        basis_waddr = clr_q;
      end
      ST_IDLE: basis_we = accept && (in_data_i.kind == KIND_WRITE) && idx_ok_in;
      ST_WB: begin
        basis_we    = (wb_q != 2'd3) && (req_q.kind == KIND_TRIANGLE);
        basis_waddr = AW'(wb_corner);
        basis_wdata = wb_row;
      end
      ST_FETCH_A: vtx_raddr = AW'(req_q.corner_a);
      ST_FETCH_B: vtx_raddr = AW'(req_q.corner_b);
      default: ;
    endcase
  end

  always_comb begin
    mul_a = du1_q;
    mul_b = dv2_q;
    unique case (state_q)
      ST_DET1: begin
        mul_a = dv1_q;
        mul_b = du2_q;
      end
      ST_NUM0: begin
        mul_a = side_q ? dp2_q[comp_q] : dp1_q[comp_q];
        mul_b = side_q ? du1_q : dv2_q;
      end
      ST_NUM1: begin
        mul_a = side_q ? dp1_q[comp_q] : dp2_q[comp_q];
        mul_b = side_q ? du2_q : dv1_q;
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign prod_ext = {{(TTB_ACC_W-TTB_PROD_W){prod[TTB_PROD_W-1]}}, prod};

  ttb_divider u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (acc_q),
    .den_i    (det_q),
    .status_o (div_status),
    .result_o (div_result)
  );

  always_ff @(posedge clk_i) begin
    if (accept && (in_data_i.kind == KIND_WRITE) && idx_ok_in) begin
      vtx_mem[AW'(in_data_i.vertex_index)] <= '{pos_x: in_data_i.pos_x,
                                                 pos_y: in_data_i.pos_y,
                                                 pos_z: in_data_i.pos_z,
                                                 tex_u: in_data_i.tex_u,
                                                 tex_v: in_data_i.tex_v};
    end
    vtx_rd_q <= vtx_mem[vtx_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (basis_we) begin
      basis_mem[basis_waddr] <= basis_wdata;
    end
    if (accept) begin
      basis_rd_q <= basis_mem[AW'(in_data_i.vertex_index)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      comp_q      <= '0;
      side_q      <= 1'b0;
      wb_q        <= '0;
      degen_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + AW'(1);
      end
      if (accept) begin
        degen_q <= 1'b0;
        wb_q    <= (in_data_i.kind == KIND_READ) ? 2'd3 : 2'd0;
      end
      if (state_q == ST_DET_CHK) begin
        degen_q <= (acc_q == '0);
        comp_q  <= '0;
        side_q  <= 1'b0;
      end
      if ((state_q == ST_DIV_WAIT) && div_status.done) begin
        side_q <= !side_q;
        if (side_q) begin
          comp_q <= comp_q + 2'd1;
        end
      end
      if ((state_q == ST_WB) && (wb_q != 2'd3)) begin
        wb_q <= wb_q + 2'd1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= in_data_i;
      if (in_data_i.kind == KIND_READ) begin
        for (int i = 0; i < 6; i++) res_q[i] <= '0;
      end
    end
    unique case (state_q)
      ST_READ_WAIT: begin
        res_q[0] <= basis_rd_q.tan_x;
        res_q[1] <= basis_rd_q.tan_y;
        res_q[2] <= basis_rd_q.tan_z;
        res_q[3] <= basis_rd_q.bitan_x;
        res_q[4] <= basis_rd_q.bitan_y;
        res_q[5] <= basis_rd_q.bitan_z;
      end
      ST_FETCH_B:   v0_q <= vtx_rd_q;
      ST_FETCH_C:   v1_q <= vtx_rd_q;
      ST_FETCH_END: v2_q <= vtx_rd_q;
      ST_DELTA: begin
        dp1_q[0] <= sub16(v1_q.pos_x, v0_q.pos_x);
        dp1_q[1] <= sub16(v1_q.pos_y, v0_q.pos_y);
        dp1_q[2] <= sub16(v1_q.pos_z, v0_q.pos_z);
        dp2_q[0] <= sub16(v2_q.pos_x, v0_q.pos_x);
        dp2_q[1] <= sub16(v2_q.pos_y, v0_q.pos_y);
        dp2_q[2] <= sub16(v2_q.pos_z, v0_q.pos_z);
        du1_q    <= sub16(v1_q.tex_u, v0_q.tex_u);
        dv1_q    <= sub16(v1_q.tex_v, v0_q.tex_v);
        du2_q    <= sub16(v2_q.tex_u, v0_q.tex_u);
        dv2_q    <= sub16(v2_q.tex_v, v0_q.tex_v);
      end
      ST_DET0, ST_NUM0: acc_q <= prod_ext;
      ST_DET1, ST_NUM1: acc_q <= acc_q - prod_ext;
      ST_DET_CHK: begin
        det_q <= acc_q;
        if (acc_q == '0) begin
          for (int i = 0; i < 6; i++) res_q[i] <= '0;
        end
      end
      ST_DIV_WAIT: if (div_status.done) res_q[res_idx] <= div_result;
      default: ;
    endcase
    if (out_load) begin
      out_data_q <= '{degenerate: degen_q,
                      tan_x: res_q[0], tan_y: res_q[1], tan_z: res_q[2],
                      bitan_x: res_q[3], bitan_y: res_q[4], bitan_z: res_q[5]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`include "triangle_tangent_basis_unit_assert.svh"

  `TTB_ASSERT_IMPL(a_degen_zero, clk_i, rst_ni, out_valid_o && out_data_o.degenerate, (out_data_o.tan_x == '0) && (out_data_o.tan_y == '0) && (out_data_o.tan_z == '0) && (out_data_o.bitan_x == '0) && (out_data_o.bitan_y == '0) && (out_data_o.bitan_z == '0), "degenerate result carries non-zero vectors")
  `TTB_ASSERT_NEVER(a_div_restart, clk_i, rst_ni, div_start && div_status.busy, "divider started while busy")
  `TTB_ASSERT_NEXT(a_tri_busy, clk_i, rst_ni, accept && (in_data_i.kind == KIND_TRIANGLE) && tri_ok, !in_ready_o, "ready straight after triangle transaction")

endmodule

// File: sim/tb_triangle_tangent_basis_unit.sv
// ----------------------------------------------------------------------------
// tb_triangle_tangent_basis_unit
// Drives vertex writes, triangle requests and basis reads through the input
// channel with random gaps and output stalls. A scoreboard model of the vertex
// and basis stores predicts the results; directed rows may carry their own
// expected result. The expected results queue is checked field by field.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_basis_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import ttb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int unsigned NVTX = 1024;

  typedef struct {
    ttb_in_t  item;
    bit       typed;
    ttb_out_t res;
  } stim_row_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_ready_o;
  ttb_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  ttb_out_t out_data_o;

  ttb_vertex_t vtx_m [NVTX];
  ttb_basis_t  basis_m [NVTX];
  bit          written [NVTX];
  ttb_out_t    result_q [$];
  stim_row_t   stim_rows [$];
  bit          cur_typed;
  ttb_out_t    cur_res;
  int          errors = 0;
  int          stall = 0;

  triangle_tangent_basis_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_data_o(out_data_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("triangle_tangent_basis_unit: mismatch");
    $finish;
  end

  function automatic logic signed [31:0] fix_div(longint num, longint den);
    bit neg;
    longint unsigned a, d, q;
    neg = (num < 0) != (den < 0);
    a = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    q = ((a << 20) * 2 + d) / (2 * d);
    if (!neg) return (q > 64'h7fff_ffff) ? 32'h7fff_ffff : q[31:0];
    if (q >= 64'h8000_0000) return 32'h8000_0000;
    return -q[31:0];
  endfunction

  function automatic longint pos_of(ttb_vertex_t v, int k);
    case (k)
      0: return longint'(v.pos_x);
      1: return longint'(v.pos_y);
      default: return longint'(v.pos_z);
    endcase
  endfunction

  // updates the stores and returns whether a result follows
  function automatic bit basis_predict(ttb_in_t it, output ttb_out_t r);
    ttb_vertex_t v0, v1, v2;
    longint du1, dv1, du2, dv2, det, p1, p2;
    logic signed [31:0] t[3], b[3];
    r = '0;
    case (it.kind)
      KIND_WRITE: begin
        vtx_m[it.vertex_index] = '{it.pos_x, it.pos_y, it.pos_z, it.tex_u, it.tex_v};
        basis_m[it.vertex_index] = '0;
        return 1'b0;
      end
      KIND_READ: begin
        {r.tan_x, r.tan_y, r.tan_z, r.bitan_x, r.bitan_y, r.bitan_z} =
          basis_m[it.vertex_index];
        return 1'b1;
      end
      KIND_TRIANGLE: begin
        v0 = vtx_m[it.corner_a];
        v1 = vtx_m[it.corner_b];
        v2 = vtx_m[it.corner_c];
        du1 = longint'(v1.tex_u) - longint'(v0.tex_u);
        dv1 = longint'(v1.tex_v) - longint'(v0.tex_v);
        du2 = longint'(v2.tex_u) - longint'(v0.tex_u);
        dv2 = longint'(v2.tex_v) - longint'(v0.tex_v);
        det = du1 * dv2 - dv1 * du2;
        for (int k = 0; k < 3; k++) begin
          t[k] = '0;
          b[k] = '0;
          if (det != 0) begin
            p1 = pos_of(v1, k) - pos_of(v0, k);
            p2 = pos_of(v2, k) - pos_of(v0, k);
            t[k] = fix_div(p1 * dv2 - p2 * dv1, det);
            b[k] = fix_div(p2 * du1 - p1 * du2, det);
          end
        end
        r = '{det == 0, t[0], t[1], t[2], b[0], b[1], b[2]};
        basis_m[it.corner_a] = {t[0], t[1], t[2], b[0], b[1], b[2]};
        basis_m[it.corner_b] = basis_m[it.corner_a];
        basis_m[it.corner_c] = basis_m[it.corner_a];
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s expected %h got %h", $realtime, what, want, got);
    errors++;
  endtask

  task automatic add_row(ttb_in_t item, bit typed, ttb_out_t res);
    stim_row_t row;
    row.item = item;
    row.typed = typed;
    row.res = res;
    stim_rows = {stim_rows, row};
  endtask

  always @(posedge clk_i) begin
    ttb_out_t r, e;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        if (basis_predict(in_data_i, r)) result_q = {result_q, (cur_typed ? cur_res : r)};
      end
      if (out_valid_o && out_ready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected transaction", '0, '0);
        end else begin
          e = result_q.pop_front();
          if (e.degenerate !== out_data_o.degenerate)
            report_mismatch("degenerate", e.degenerate, out_data_o.degenerate);
          if (e.tan_x !== out_data_o.tan_x) report_mismatch("tan_x", e.tan_x, out_data_o.tan_x);
          if (e.tan_y !== out_data_o.tan_y) report_mismatch("tan_y", e.tan_y, out_data_o.tan_y);
          if (e.tan_z !== out_data_o.tan_z) report_mismatch("tan_z", e.tan_z, out_data_o.tan_z);
          if (e.bitan_x !== out_data_o.bitan_x)
            report_mismatch("bitan_x", e.bitan_x, out_data_o.bitan_x);
          if (e.bitan_y !== out_data_o.bitan_y)
            report_mismatch("bitan_y", e.bitan_y, out_data_o.bitan_y);
          if (e.bitan_z !== out_data_o.bitan_z)
            report_mismatch("bitan_z", e.bitan_z, out_data_o.bitan_z);
        end
      end
    end
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 300);
  endfunction

  always @(negedge clk_i) begin
    if (stall > 0) begin
      stall--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall = gap_len();
    end
  end

  function automatic logic [15:0] coord16(bit narrow);
    int p;
    p = $urandom_range(9);
    if (p == 0) return 16'h8000;
    if (p == 1) return 16'h7fff;
    if (narrow || p < 5) return 16'($signed($urandom_range(0, 512)) - 256);
    return 16'($urandom);
  endfunction

  function automatic ttb_in_t make_item(logic [1:0] kind, int idx, int px, int py, int pz,
                                        int u, int v, int a, int b, int c);
    ttb_in_t it;
    it = '{kind, idx[9:0], px[15:0], py[15:0], pz[15:0], u[15:0], v[15:0],
           a[9:0], b[9:0], c[9:0]};
    return it;
  endfunction

  function automatic int pick_written();
    int i;
    do i = $urandom_range(0, 63); while (!written[i]);
    return i;
  endfunction

  task automatic issue(ttb_in_t it, bit typed, ttb_out_t res);
    int g;
    if (it.kind == KIND_WRITE) written[it.vertex_index] = 1'b1;
    cur_typed = typed;
    cur_res = res;
    in_data_i = it;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    @(negedge clk_i);
    g = gap_len();
    if (g > 0) begin
      in_valid_i = 1'b0;
      in_data_i = ttb_in_t'({$urandom, $urandom, $urandom, $urandom});
      repeat (g) @(negedge clk_i);
    end
  endtask

  initial begin
    ttb_out_t sat, nil, degen;
    ttb_in_t it;
    int p, a, b, c, idx;
    nil = '0;
    degen = '0;
    degen.degenerate = 1'b1;
    sat = '{1'b0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0};
    foreach (vtx_m[i]) begin
      vtx_m[i] = '0;
      basis_m[i] = '0;
      written[i] = 1'b0;
    end

    add_row(make_item(KIND_READ, 1023, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, nil);
    add_row(make_item(KIND_UNUSED, 7, 5, 5, 5, 5, 5, 1, 2, 3), 1'b0, nil);
    add_row(make_item(KIND_WRITE, 0, -32768, -32768, -32768, 0, 0, 0, 0, 0), 1'b0, nil);
    add_row(make_item(KIND_WRITE, 1, 32767, 32767, 32767, 1, 0, 0, 0, 0), 1'b0, nil);
    add_row(make_item(KIND_WRITE, 2, -32768, -32768, -32768, 0, 1, 0, 0, 0), 1'b0, nil);
    add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 0, 0, 1, 2), 1'b1, sat);
    add_row(make_item(KIND_READ, 1, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, sat);
    add_row(make_item(KIND_WRITE, 3, 32767, -1, 0, -32768, 32767, 0, 0, 0), 1'b0, nil);
    add_row(make_item(KIND_WRITE, 4, 4660, -300, 77, 32767, -32768, 0, 0, 0), 1'b0, nil);
    add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 0, 0, 3, 4), 1'b0, nil);
    add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 0, 2, 3, 4), 1'b0, nil);
    add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 0, 0, 0, 1), 1'b1, degen);
    add_row(make_item(KIND_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, nil);
    add_row(make_item(KIND_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, nil);
    add_row(make_item(KIND_WRITE, 3, 256, 512, -256, 4096, 0, 0, 0, 0), 1'b0, nil);
    add_row(make_item(KIND_READ, 3, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, nil);
    add_row(make_item(KIND_TRIANGLE, 0, 0, 0, 0, 0, 0, 3, 4, 1), 1'b0, nil);
    add_row(make_item(KIND_READ, 4, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, nil);

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (stim_rows[i]) issue(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].res);

    for (int n = 0; n < 600; n++) begin
      it = ttb_in_t'({$urandom, $urandom, $urandom, $urandom});
      p = $urandom_range(99);
      if (p < 30) begin
        it.kind = KIND_WRITE;
        idx = ($urandom_range(3) == 0) ? $urandom_range(0, NVTX - 1) : $urandom_range(0, 63);
        it.vertex_index = idx[9:0];
        it.pos_x = coord16(1'b0);
        it.pos_y = coord16(1'b0);
        it.pos_z = coord16(1'b0);
        it.tex_u = coord16(1'($urandom_range(1)));
        it.tex_v = coord16(1'($urandom_range(1)));
      end else if (p < 75) begin
        it.kind = KIND_TRIANGLE;
        a = pick_written();
        b = pick_written();
        c = ($urandom_range(9) == 0) ? a : pick_written();
        it.corner_a = a[9:0];
        it.corner_b = b[9:0];
        it.corner_c = c[9:0];
      end else if (p < 95) begin
        it.kind = KIND_READ;
        idx = ($urandom_range(3) == 0) ? $urandom_range(0, NVTX - 1) : $urandom_range(0, 63);
        it.vertex_index = idx[9:0];
      end else begin
        it.kind = KIND_UNUSED;
      end
      issue(it, 1'b0, nil);
    end

    in_valid_i = 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    if (errors == 0) begin
      $display("triangle_tangent_basis_unit: match");
    end else begin
      $display("triangle_tangent_basis_unit: mismatch");
    end
    $finish;
  end
endmodule
